FILE: rtl/ray_box_hit_point_macros.svh
// Assertion macros for the ray_box_hit_point checker.
// No dependencies.
`ifndef RAY_BOX_HIT_POINT_MACROS_SVH
`define RAY_BOX_HIT_POINT_MACROS_SVH

// same-cycle implication
`define RBHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define RBHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/rbhp_pkg.sv
// Shared types, constants and helpers for ray_box_hit_point.
// No dependencies.
package rbhp_pkg;

    localparam int CW        = 32;
    localparam int FB        = 16;
    localparam int QW        = CW + FB;
    localparam int TW        = QW + 1;
    localparam int TLO       = 24;
    localparam int THI       = TW - TLO;
    localparam int PPW       = CW + THI;
    localparam int PW        = CW + TW;
    localparam int EW        = PW - FB + 1;
    localparam int DIV_STEPS = QW;
    localparam int ST_DIR    = DIV_STEPS + 2;
    localparam int ST_POS    = ST_DIR + 2;
    localparam int LAT       = ST_POS + 6;
    localparam int NFACE     = 6;
    localparam int INW       = 6 * CW;
    localparam int OUTW      = ((1 + 3 * CW + 7) / 8) * 8;
    localparam int IDXW      = 3;

    localparam logic [IDXW-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDXW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDXW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDXW-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDXW-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDXW-1:0] REG_MAX_Z = 3'd5;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t RST_MIN_X = -32'sd3276800;
    localparam coord_t RST_MIN_Y = -32'sd3276800;
    localparam coord_t RST_MIN_Z = 32'sd0;
    localparam coord_t RST_MAX_X = 32'sd3276800;
    localparam coord_t RST_MAX_Y = 32'sd3276800;
    localparam coord_t RST_MAX_Z = 32'sd6553600;

    typedef struct packed {
        coord_t dz;
        coord_t dy;
        coord_t dx;
        coord_t pz;
        coord_t py;
        coord_t px;
    } line_t;

    typedef struct packed {
        logic [QW-1:0] num;
        logic [CW-1:0] dv;
        logic          neg;
        logic          par;
    } div_t;

    typedef struct packed {
        logic                 hit;
        logic signed [TW-1:0] t;
        coord_t               x;
        coord_t               y;
        coord_t               z;
    } hit_t;

    // farther hit wins, earlier (left) face on a tie
    function automatic hit_t pick_hit(input hit_t a, input hit_t b);
        if (b.hit && (!a.hit || (b.t > a.t)))
            return b;
        return a;
    endfunction

endpackage

FILE: rtl/rbhp_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Depends on rbhp_pkg.
module rbhp_div (
    input  logic                      clk,
    input  logic                      en,
    input  rbhp_pkg::div_t            din,
    output logic [rbhp_pkg::QW-1:0]   q,
    output logic                      neg,
    output logic                      par
);
    import rbhp_pkg::*;

    logic [CW-1:0] rem_reg [DIV_STEPS];
    logic [QW-1:0] num_reg [DIV_STEPS];
    logic [CW-1:0] dv_reg  [DIV_STEPS];
    logic          neg_reg [DIV_STEPS];
    logic          par_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [CW-1:0] rem_in;
            logic [QW-1:0] num_in;
            logic [CW-1:0] dv_in;
            logic          neg_in;
            logic          par_in;
            logic [CW:0]   r2;
            logic          ge;
            logic [CW:0]   diff;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = din.num;
                assign dv_in  = din.dv;
                assign neg_in = din.neg;
                assign par_in = din.par;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign num_in = num_reg[k-1];
                assign dv_in  = dv_reg[k-1];
                assign neg_in = neg_reg[k-1];
                assign par_in = par_reg[k-1];
            end

            assign r2   = {rem_in, num_in[QW-1]};
            assign ge   = (r2 >= {1'b0, dv_in});
            assign diff = r2 - {1'b0, dv_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[CW-1:0] : r2[CW-1:0];
                    num_reg[k] <= {num_in[QW-2:0], ge};
                    dv_reg[k]  <= dv_in;
                    neg_reg[k] <= neg_in;
                    par_reg[k] <= par_in;
                end
            end
        end
    endgenerate

    assign q   = num_reg[DIV_STEPS-1];
    assign neg = neg_reg[DIV_STEPS-1];
    assign par = par_reg[DIV_STEPS-1];

endmodule

FILE: rtl/rbhp_face.sv
// One face lane: line parameter by division, hit point on the other two axes, bounds test.
// Depends on rbhp_pkg and rbhp_div.
module rbhp_face (
    input  logic                           clk,
    input  logic                           en,
    input  rbhp_pkg::coord_t               f,
    input  rbhp_pkg::coord_t               pa,
    input  rbhp_pkg::coord_t               da,
    input  rbhp_pkg::coord_t               db0,
    input  rbhp_pkg::coord_t               db1,
    input  rbhp_pkg::coord_t               pb0,
    input  rbhp_pkg::coord_t               pb1,
    input  rbhp_pkg::coord_t               lo0,
    input  rbhp_pkg::coord_t               hi0,
    input  rbhp_pkg::coord_t               lo1,
    input  rbhp_pkg::coord_t               hi1,
    output logic                           hit,
    output logic signed [rbhp_pkg::TW-1:0] t,
    output rbhp_pkg::coord_t               e0,
    output rbhp_pkg::coord_t               e1
);
    import rbhp_pkg::*;

    logic signed [CW:0]    diff;
    logic [CW:0]           diff_neg;
    logic [CW-1:0]         mag;
    logic [CW-1:0]         dmag;
    div_t                  prep_next, prep_reg;

    logic [QW-1:0]         q;
    logic                  qneg, qpar;

    logic signed [TW-1:0]  t_next, t_reg, t2_reg, t3_reg, t4_reg;
    logic                  par_reg, par2_reg, par3_reg;

    logic signed [PPW-1:0] plo0_reg, phi0_reg, plo1_reg, phi1_reg;
    logic signed [PW-1:0]  p0_next, p1_next, p0_reg, p1_reg;
    logic signed [PW-1:0]  sh0, sh1;
    logic                  c0, c1;
    logic signed [EW-1:0]  e0_next, e1_next, e0_reg, e1_reg;
    logic                  par4_reg;
    logic                  in0, in1;

    always_comb
    begin
        diff     = {f[CW-1], f} - {pa[CW-1], pa};
        diff_neg = -diff;
        mag      = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];
        dmag     = da[CW-1] ? (~da + 1'b1) : da;
        prep_next.num = QW'(mag) << FB;
        prep_next.dv  = dmag;
        prep_next.neg = diff[CW] ^ da[CW-1];
        prep_next.par = (da == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    rbhp_div u_div (
        .clk (clk),
        .en  (en),
        .din (prep_reg),
        .q   (q),
        .neg (qneg),
        .par (qpar)
    );

    assign t_next = qneg ? -$signed({1'b0, q}) : $signed({1'b0, q});

    always_comb
    begin
        sh0     = p0_reg >>> FB;
        sh1     = p1_reg >>> FB;
        c0      = p0_reg[PW-1] && (p0_reg[FB-1:0] != '0);
        c1      = p1_reg[PW-1] && (p1_reg[FB-1:0] != '0);
        p0_next = (PW'(phi0_reg) <<< TLO) + PW'(plo0_reg);
        p1_next = (PW'(phi1_reg) <<< TLO) + PW'(plo1_reg);
        e0_next = EW'(pb0) + EW'(sh0) + EW'(c0);
        e1_next = EW'(pb1) + EW'(sh1) + EW'(c1);
        in0     = (e0_reg >= EW'(lo0)) && (e0_reg <= EW'(hi0));
        in1     = (e1_reg >= EW'(lo1)) && (e1_reg <= EW'(hi1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t_next;
            par_reg  <= qpar;

            plo0_reg <= db0 * $signed({1'b0, t_reg[TLO-1:0]});
            phi0_reg <= db0 * $signed(t_reg[TW-1:TLO]);
            plo1_reg <= db1 * $signed({1'b0, t_reg[TLO-1:0]});
            phi1_reg <= db1 * $signed(t_reg[TW-1:TLO]);
            t2_reg   <= t_reg;
            par2_reg <= par_reg;

            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            t3_reg   <= t2_reg;
            par3_reg <= par2_reg;

            e0_reg   <= e0_next;
            e1_reg   <= e1_next;
            t4_reg   <= t3_reg;
            par4_reg <= par3_reg;

            hit      <= !par4_reg && in0 && in1;
            t        <= t4_reg;
            e0       <= e0_reg[CW-1:0];
            e1       <= e1_reg[CW-1:0];
        end
    end

endmodule

FILE: rtl/rbhp_pick.sv
// Registered three-level tree that keeps the farthest face hit, zeros on a miss.
// Depends on rbhp_pkg.
module rbhp_pick (
    input  logic           clk,
    input  logic           en,
    input  rbhp_pkg::hit_t res [rbhp_pkg::NFACE],
    output rbhp_pkg::hit_t best
);
    import rbhp_pkg::*;

    hit_t l1_reg [3];
    hit_t l2a_reg, l2b_reg;
    hit_t fin;

    always_comb
    begin
        fin = pick_hit(l2a_reg, l2b_reg);
        if (!fin.hit)
            fin = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg[0] <= pick_hit(res[0], res[1]);
            l1_reg[1] <= pick_hit(res[2], res[3]);
            l1_reg[2] <= pick_hit(res[4], res[5]);
            l2a_reg   <= pick_hit(l1_reg[0], l1_reg[1]);
            l2b_reg   <= l1_reg[2];
            best      <= fin;
        end
    end

endmodule

FILE: rtl/ray_box_hit_point.sv
// Throughput: one beat per cycle while the output is not stalled; six 48-stage divider
// pipelines, one per face, set the depth.
// A stall on the output freezes every stage together; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default box (-50,-50,0)..(50,50,100).
// Depends on rbhp_pkg, rbhp_face, rbhp_pick.
module ray_box_hit_point (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z (32 bits each, low to high)
    input  logic [rbhp_pkg::INW-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // box_hit, hit_x, hit_y, hit_z, zero pad (low to high)
    output logic [rbhp_pkg::OUTW-1:0]   m_axis_tdata,
    input  logic                        cfg_we,
    input  logic [rbhp_pkg::IDXW-1:0]   cfg_index,
    input  logic [rbhp_pkg::CW-1:0]     cfg_data
);
    import rbhp_pkg::*;

    coord_t lo_reg [3];
    coord_t hi_reg [3];
    line_t  pd_reg [ST_POS+1];
    logic   v_reg  [LAT];
    logic   en;

    coord_t pos0 [3], dir0 [3], dirs [3], poss [3];
    hit_t   res [NFACE];
    hit_t   best;

    assign en            = !v_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[LAT-1];
    assign m_axis_tdata  = {(OUTW-1-3*CW)'(0), best.z, best.y, best.x, best.hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg[0] <= RST_MIN_X;
            lo_reg[1] <= RST_MIN_Y;
            lo_reg[2] <= RST_MIN_Z;
            hi_reg[0] <= RST_MAX_X;
            hi_reg[1] <= RST_MAX_Y;
            hi_reg[2] <= RST_MAX_Z;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_X: lo_reg[0] <= cfg_data;
                REG_MIN_Y: lo_reg[1] <= cfg_data;
                REG_MIN_Z: lo_reg[2] <= cfg_data;
                REG_MAX_X: hi_reg[0] <= cfg_data;
                REG_MAX_Y: hi_reg[1] <= cfg_data;
                REG_MAX_Z: hi_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg[0] <= line_t'(s_axis_tdata);
            for (int i = 1; i <= ST_POS; i++)
                pd_reg[i] <= pd_reg[i-1];
        end
    end

    always_comb
    begin
        pos0[0] = pd_reg[0].px;      pos0[1] = pd_reg[0].py;      pos0[2] = pd_reg[0].pz;
        dir0[0] = pd_reg[0].dx;      dir0[1] = pd_reg[0].dy;      dir0[2] = pd_reg[0].dz;
        dirs[0] = pd_reg[ST_DIR].dx; dirs[1] = pd_reg[ST_DIR].dy; dirs[2] = pd_reg[ST_DIR].dz;
        poss[0] = pd_reg[ST_POS].px; poss[1] = pd_reg[ST_POS].py; poss[2] = pd_reg[ST_POS].pz;
    end

    genvar k;
    generate
        for (k = 0; k < NFACE; k++)
        begin : g_face
            localparam int A  = k % 3;
            localparam int B0 = (A + 1) % 3;
            localparam int B1 = (A + 2) % 3;

            coord_t               f;
            logic                 fh;
            logic signed [TW-1:0] ft;
            coord_t               e0, e1;

            assign f = (k < 3) ? lo_reg[A] : hi_reg[A];

            rbhp_face u_face (
                .clk (clk),
                .en  (en),
                .f   (f),
                .pa  (pos0[A]),
                .da  (dir0[A]),
                .db0 (dirs[B0]),
                .db1 (dirs[B1]),
                .pb0 (poss[B0]),
                .pb1 (poss[B1]),
                .lo0 (lo_reg[B0]),
                .hi0 (hi_reg[B0]),
                .lo1 (lo_reg[B1]),
                .hi1 (hi_reg[B1]),
                .hit (fh),
                .t   (ft),
                .e0  (e0),
                .e1  (e1)
            );

            always_comb
            begin
                res[k].hit = fh;
                res[k].t   = ft;
                res[k].x   = (A == 0) ? f : ((B0 == 0) ? e0 : e1);
                res[k].y   = (A == 1) ? f : ((B0 == 1) ? e0 : e1);
                res[k].z   = (A == 2) ? f : ((B0 == 2) ? e0 : e1);
            end
        end
    endgenerate

    rbhp_pick u_pick (
        .clk  (clk),
        .en   (en),
        .res  (res),
        .best (best)
    );

endmodule

FILE: rtl/rbhp_checker.sv
// Port-level checker for ray_box_hit_point, bound to the top level.
// Depends on rbhp_pkg and ray_box_hit_point_macros.svh.
`include "ray_box_hit_point_macros.svh"

module rbhp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rbhp_pkg::OUTW-1:0]   m_axis_tdata
);
    import rbhp_pkg::*;

    logic out_stall;
    logic out_miss;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_miss  = m_axis_tvalid && !m_axis_tdata[0];

    `RBHP_ASSERT_IMP(a_ready_free, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `RBHP_ASSERT_IMP(a_ready_stall, clk, rst_n, out_stall, !s_axis_tready)
    `RBHP_ASSERT_IMP(a_miss_zero, clk, rst_n, out_miss, m_axis_tdata[3*CW:1] == '0)
    `RBHP_ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[OUTW-1:3*CW+1] == '0)
    `RBHP_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ray_box_hit_point rbhp_checker u_rbhp_checker (.*);
